// ----- hdl/ksm_pkg.sv -----
// package: sizes, codes and payload types of the key sequence matcher
`timescale 1ns / 1ps
package ksm_pkg;

  localparam int BUF_DEPTH = 20;
  localparam int N_ENTRIES = 32;
  localparam int MAX_LEN   = 16;

  localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
  localparam int BIDX_W = $clog2(BUF_DEPTH);
  localparam int ENT_W  = $clog2(N_ENTRIES + 1);
  localparam int EIDX_W = $clog2(N_ENTRIES);
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int CPOS_W = $clog2(MAX_LEN);
  localparam int ADDR_W = EIDX_W + CPOS_W;

  typedef enum logic [1:0] {
    OP_KEY     = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_WR_CHAR = 2'd2,
    OP_WR_CODE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_PLAIN    = 2'd0,
    KIND_CODE     = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  localparam logic REG_ENTRIES = 1'b0;
  localparam logic REG_DISCARD = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  key_byte;
    logic [4:0]  entry_index;
    logic [3:0]  char_position;
    logic [15:0] entry_code;
    logic [4:0]  entry_length;
  } item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] result_value;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic        index;
    logic [5:0]  value;
  } cfg_word_t;

endpackage

// ----- hdl/ksm_if.sv -----
// interfaces: item, result and configuration channels
`timescale 1ns / 1ps
interface ksm_in_if;
  logic          valid;
  logic          ready;
  ksm_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ksm_out_if;
  logic            valid;
  logic            ready;
  ksm_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ksm_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [5:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/key_sequence_matcher.sv -----
// top level: buffers key bytes and prefix-matches them against the sequence table
// table writes and empty timeouts are handled in the idle state; a key byte is accepted, then
// scans walk each buffered position over the entries, skipping dead and dropping finished ones,
// with a compare state per live entry (one port of the character memory), rescanned after each
// oldest-byte pop; each result word passes the push state and waits there while the output stalls
// results leave through an output register one word behind; ready only between items
// reset (rst, synchronous): buffer empty, all entries live and unused, registers zero
`timescale 1ns / 1ps
module key_sequence_matcher (
  input logic clk,
  input logic rst,
  ksm_in_if.sink    key_in,
  ksm_out_if.source res_out,
  ksm_cfg_if.sink   cfg
);

  typedef enum logic [2:0] {
    S_IDLE, S_RSTART, S_SCAN, S_CMP, S_POP, S_PUSH, S_FINISH
  } state_t;

  state_t state, ret;

  logic [ksm_pkg::CNT_W-1:0]  count;
  logic [ksm_pkg::N_ENTRIES-1:0] live;
  logic [7:0] kbuf [ksm_pkg::BUF_DEPTH];
  logic [7:0] chars [2**ksm_pkg::ADDR_W];
  logic [7:0] rdata;
  logic [15:0] codes [ksm_pkg::N_ENTRIES];
  logic [ksm_pkg::LEN_W-1:0] lens [ksm_pkg::N_ENTRIES];
  logic [5:0] entries_in_use;
  logic       discard_unmatched;

  logic [ksm_pkg::CNT_W-1:0] pos;
  logic [ksm_pkg::ENT_W-1:0] ent;

  logic        pend_valid;
  logic [1:0]  pend_kind;
  logic [15:0] pend_value;
  logic [1:0]  new_kind;
  logic [15:0] new_value;

  logic        out_valid;
  ksm_pkg::result_t out_data;

  logic [ksm_pkg::ENT_W-1:0] n_act;
  logic [ksm_pkg::N_ENTRIES-1:0] range_mask;
  logic [ksm_pkg::EIDX_W-1:0] eidx;
  logic [ksm_pkg::LEN_W-1:0] cur_len;
  logic [ksm_pkg::ADDR_W-1:0] rd_addr;
  logic out_free;
  logic out_load;
  ksm_pkg::item_t it;
  logic [ksm_pkg::CNT_W-1:0] count_inc;
  logic [ksm_pkg::LEN_W-1:0] len_clamped;

  assign it = key_in.data;
  assign key_in.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign res_out.valid = out_valid;
  assign res_out.data = out_data;
  assign out_free = !out_valid || res_out.ready;
  assign out_load = pend_valid && out_free && (state == S_PUSH || state == S_FINISH);

  assign n_act = (entries_in_use > 6'(ksm_pkg::N_ENTRIES)) ?
                 ksm_pkg::ENT_W'(ksm_pkg::N_ENTRIES) : ksm_pkg::ENT_W'(entries_in_use);
  assign eidx = ent[ksm_pkg::EIDX_W-1:0];
  assign cur_len = lens[eidx];
  assign rd_addr = {eidx, pos[ksm_pkg::CPOS_W-1:0]};
  assign count_inc = count + 1'b1;
  assign len_clamped = (it.entry_length > 5'(ksm_pkg::MAX_LEN)) ?
                       ksm_pkg::LEN_W'(ksm_pkg::MAX_LEN) : ksm_pkg::LEN_W'(it.entry_length);

  always_comb begin
    for (int i = 0; i < ksm_pkg::N_ENTRIES; i++) begin
      range_mask[i] = (ksm_pkg::ENT_W'(i) < n_act);
    end
  end

  // character table memory
  always_ff @(posedge clk) begin
    if (key_in.valid && key_in.ready && it.opcode == ksm_pkg::OP_WR_CHAR) begin
      chars[{it.entry_index[ksm_pkg::EIDX_W-1:0], it.char_position[ksm_pkg::CPOS_W-1:0]}]
        <= it.key_byte;
    end
    rdata <= chars[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= S_IDLE;
      count <= '0;
      live <= '1;
      entries_in_use <= '0;
      discard_unmatched <= 1'b0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
      pos <= '0;
      ent <= '0;
      for (int i = 0; i < ksm_pkg::N_ENTRIES; i++) lens[i] <= '0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (res_out.ready) out_valid <= 1'b0;
      if (cfg.valid) begin
        unique case (cfg.index)
          ksm_pkg::REG_ENTRIES: entries_in_use <= cfg.data;
          ksm_pkg::REG_DISCARD: discard_unmatched <= cfg.data[0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (key_in.valid) begin
            unique case (it.opcode)
              ksm_pkg::OP_KEY: begin
                if (n_act == '0) begin
                  new_kind <= ksm_pkg::KIND_PLAIN;
                  new_value <= {8'd0, it.key_byte};
                  ret <= S_FINISH;
                  state <= S_PUSH;
                end else begin
                  kbuf[count[ksm_pkg::BIDX_W-1:0]] <= it.key_byte;
                  if (count_inc >= ksm_pkg::CNT_W'(ksm_pkg::BUF_DEPTH - 1)) begin
                    count <= '0;
                    live <= '1;
                    new_kind <= ksm_pkg::KIND_OVERFLOW;
                    new_value <= '0;
                    ret <= S_FINISH;
                    state <= S_PUSH;
                  end else begin
                    count <= count_inc;
                    state <= S_RSTART;
                  end
                end
              end
              ksm_pkg::OP_TIMEOUT: begin
                if (count != '0) state <= S_POP;
              end
              ksm_pkg::OP_WR_CHAR: ;
              ksm_pkg::OP_WR_CODE: begin
                codes[it.entry_index[ksm_pkg::EIDX_W-1:0]] <= it.entry_code;
                lens[it.entry_index[ksm_pkg::EIDX_W-1:0]] <= len_clamped;
              end
              default: ;
            endcase
          end
        end
        S_RSTART: begin
          pos <= '0;
          ent <= '0;
          state <= (count == '0) ? S_FINISH : S_SCAN;
        end
        S_SCAN: begin
          if (pos >= count) begin
            state <= ((live & range_mask) != '0) ? S_FINISH : S_POP;
          end else if (ent >= n_act) begin
            pos <= pos + 1'b1;
            ent <= '0;
          end else if (!live[eidx]) begin
            ent <= ent + 1'b1;
          end else if (cur_len == '0 || ksm_pkg::LEN_W'(pos) >= cur_len ||
                       pos >= ksm_pkg::CNT_W'(ksm_pkg::MAX_LEN)) begin
            live[eidx] <= 1'b0;
            ent <= ent + 1'b1;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (rdata == kbuf[pos[ksm_pkg::BIDX_W-1:0]]) begin
            if (ksm_pkg::LEN_W'(pos + 1'b1) == cur_len) begin
              new_kind <= ksm_pkg::KIND_CODE;
              new_value <= codes[eidx];
              count <= '0;
              live <= '1;
              ret <= S_FINISH;
              state <= S_PUSH;
            end else begin
              ent <= ent + 1'b1;
              state <= S_SCAN;
            end
          end else begin
            live[eidx] <= 1'b0;
            ent <= ent + 1'b1;
            state <= S_SCAN;
          end
        end
        S_POP: begin
          for (int i = 0; i < ksm_pkg::BUF_DEPTH - 1; i++) kbuf[i] <= kbuf[i+1];
          count <= count - 1'b1;
          live <= '1;
          if (discard_unmatched) begin
            state <= S_RSTART;
          end else begin
            new_kind <= ksm_pkg::KIND_PLAIN;
            new_value <= {8'd0, kbuf[0]};
            ret <= S_RSTART;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!pend_valid) begin
            pend_valid <= 1'b1;
            pend_kind <= new_kind;
            pend_value <= new_value;
            state <= ret;
          end else if (out_free) begin
            out_data <= '{result_kind: pend_kind, result_value: pend_value,
                          last_result: 1'b0};
            pend_kind <= new_kind;
            pend_value <= new_value;
            state <= ret;
          end
        end
        S_FINISH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_data <= '{result_kind: pend_kind, result_value: pend_value,
                          last_result: 1'b1};
            pend_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// testbench: key sequence matcher checked word by word against a built-in predictor
`timescale 1ns / 1ps
module tb_top;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 5000;

  logic clk;
  logic rst;

  ksm_in_if  key_in ();
  ksm_out_if res_out ();
  ksm_cfg_if cfg ();

  key_sequence_matcher dut (
    .clk(clk),
    .rst(rst),
    .key_in(key_in),
    .res_out(res_out),
    .cfg(cfg)
  );

  // predictor state
  logic [7:0]  kbuf [ksm_pkg::BUF_DEPTH];
  int          kcount;
  logic [63:0] live;
  logic [7:0]  seq_chars [ksm_pkg::N_ENTRIES][ksm_pkg::MAX_LEN];
  int          seq_len [ksm_pkg::N_ENTRIES];
  logic [15:0] seq_code [ksm_pkg::N_ENTRIES];
  int          entries_cfg;
  bit          discard_cfg;

  ksm_pkg::item_t   pending_words[$];
  ksm_pkg::result_t expected_results[$];
  ksm_pkg::result_t step_results[$];

  int  errors;
  int  idle_cnt;
  int  stall_cnt;
  int  quiet_cnt;
  int  watchdog;
  bit  quiet;
  bit  in_fire;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic ksm_pkg::item_t make_word(ksm_pkg::opcode_t op, logic [7:0] b,
                                               logic [4:0] idx, logic [3:0] cpos,
                                               logic [15:0] code, logic [4:0] len);
    ksm_pkg::item_t w;
    w.opcode = op;
    w.key_byte = b;
    w.entry_index = idx;
    w.char_position = cpos;
    w.entry_code = code;
    w.entry_length = len;
    return w;
  endfunction

  function automatic ksm_pkg::item_t key_word(logic [7:0] b);
    return make_word(ksm_pkg::OP_KEY, b, 5'($urandom), 4'($urandom), 16'($urandom),
                     5'($urandom));
  endfunction

  function automatic ksm_pkg::item_t tick_word();
    return make_word(ksm_pkg::OP_TIMEOUT, 8'($urandom), 5'($urandom), 4'($urandom),
                     16'($urandom), 5'($urandom));
  endfunction

  function automatic int active_count();
    return (entries_cfg > ksm_pkg::N_ENTRIES) ? ksm_pkg::N_ENTRIES : entries_cfg;
  endfunction

  function automatic void add_result(ksm_pkg::kind_t k, logic [15:0] v);
    ksm_pkg::result_t r;
    r.result_kind = k;
    r.result_value = v;
    r.last_result = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic int scan_table();
    int n;
    logic [63:0] bit_e;
    n = active_count();
    for (int p = 0; p < kcount && p < ksm_pkg::BUF_DEPTH; p++) begin
      for (int e = 0; e < n; e++) begin
        bit_e = 64'd1 << e;
        if ((live & bit_e) == 0) continue;
        if (seq_len[e] == 0 || p >= seq_len[e] || p >= ksm_pkg::MAX_LEN) begin
          live &= ~bit_e;
          continue;
        end
        if (seq_chars[e][p] == kbuf[p]) begin
          if (p + 1 == seq_len[e]) return e;
        end else begin
          live &= ~bit_e;
        end
      end
    end
    return ((live & ((64'd1 << n) - 1)) != 0) ? -1 : -2;
  endfunction

  function automatic void drop_oldest();
    if (kcount == 0) return;
    if (!discard_cfg) add_result(ksm_pkg::KIND_PLAIN, {8'd0, kbuf[0]});
    kcount--;
    for (int i = 0; i < kcount; i++) kbuf[i] = kbuf[i + 1];
    live = '1;
  endfunction

  function automatic void settle_buffer();
    int r;
    while (kcount > 0) begin
      r = scan_table();
      if (r == -1) return;
      if (r >= 0) begin
        add_result(ksm_pkg::KIND_CODE, seq_code[r]);
        kcount = 0;
        live = '1;
        return;
      end
      drop_oldest();
    end
  endfunction

  function automatic void predict_word(ksm_pkg::item_t w);
    step_results.delete();
    case (ksm_pkg::opcode_t'(w.opcode))
      ksm_pkg::OP_KEY: begin
        if (active_count() == 0) begin
          add_result(ksm_pkg::KIND_PLAIN, {8'd0, w.key_byte});
        end else begin
          if (kcount < ksm_pkg::BUF_DEPTH) kbuf[kcount] = w.key_byte;
          kcount++;
          if (kcount >= ksm_pkg::BUF_DEPTH - 1) begin
            add_result(ksm_pkg::KIND_OVERFLOW, 16'd0);
            kcount = 0;
            live = '1;
          end else begin
            settle_buffer();
          end
        end
      end
      ksm_pkg::OP_TIMEOUT: begin
        if (kcount > 0) begin
          drop_oldest();
          settle_buffer();
        end
      end
      ksm_pkg::OP_WR_CHAR: seq_chars[w.entry_index][w.char_position] = w.key_byte;
      default: begin
        seq_code[w.entry_index] = w.entry_code;
        seq_len[w.entry_index] = (w.entry_length > ksm_pkg::MAX_LEN) ? ksm_pkg::MAX_LEN
                                                                      : w.entry_length;
      end
    endcase
    if (step_results.size() > 0) step_results[step_results.size() - 1].last_result = 1'b1;
    foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endfunction

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      key_in.valid <= 1'b0;
    end else if (!key_in.valid || in_fire) begin
      if (idle_cnt > 0) begin
        key_in.valid <= 1'b0;
        idle_cnt <= idle_cnt - 1;
      end else if (pending_words.size() > 0) begin
        key_in.data <= pending_words.pop_front();
        key_in.valid <= 1'b1;
        if (!quiet && $urandom_range(0, 11) == 0) idle_cnt <= $urandom_range(1, 11);
      end else begin
        key_in.valid <= 1'b0;
      end
    end
  end

  // output ready driver
  always @(negedge clk) begin
    if (rst || quiet) begin
      res_out.ready <= 1'b1;
    end else if (stall_cnt > 0) begin
      res_out.ready <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else begin
      res_out.ready <= 1'b1;
      if (quiet_cnt > 0) quiet_cnt <= quiet_cnt - 1;
      else if ($urandom_range(0, 9) == 0) stall_cnt <= $urandom_range(1, 11);
      else if ($urandom_range(0, 19) == 0) quiet_cnt <= $urandom_range(20, 60);
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    ksm_pkg::result_t want;
    bit fired;
    bit moved;
    fired = 1'b0;
    moved = 1'b0;
    if (!rst) begin
      if (key_in.valid && key_in.ready) begin
        fired = 1'b1;
        moved = 1'b1;
        predict_word(key_in.data);
      end
      if (cfg.valid && cfg.ready) moved = 1'b1;
      if (res_out.valid && res_out.ready) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          $error("unexpected result word kind=%0d value=%0h", res_out.data.result_kind,
                 res_out.data.result_value);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (res_out.data.result_kind !== want.result_kind) begin
            $error("result_kind expected %0d actual %0d", want.result_kind,
                   res_out.data.result_kind);
            errors++;
          end
          if (res_out.data.result_value !== want.result_value) begin
            $error("result_value expected %0h actual %0h", want.result_value,
                   res_out.data.result_value);
            errors++;
          end
          if (res_out.data.last_result !== want.last_result) begin
            $error("last_result expected %0d actual %0d", want.last_result,
                   res_out.data.last_result);
            errors++;
          end
        end
      end
      if (moved) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
    in_fire <= fired;
  end

  task automatic write_reg(logic [0:0] idx, logic [5:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx == ksm_pkg::REG_ENTRIES) entries_cfg = val;
    else discard_cfg = val[0];
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || key_in.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] seq_char();
    logic [7:0] alphabet [5] = '{8'h1b, 8'h5b, 8'h41, 8'h31, 8'h7e};
    return alphabet[$urandom_range(0, 4)];
  endfunction

  function automatic void send_entry(int e, int upto);
    for (int p = 0; p < upto && p < seq_len[e]; p++)
      pending_words.push_back(key_word(seq_chars[e][p]));
  endfunction

  // loads every character that a stored length can reach, and every code
  function automatic void load_table();
    int len;
    int chars_n;
    for (int e = 0; e < ksm_pkg::N_ENTRIES; e++) begin
      chars_n = (e == 31) ? ksm_pkg::MAX_LEN : 6;
      for (int p = 0; p < chars_n; p++)
        pending_words.push_back(make_word(ksm_pkg::OP_WR_CHAR,
                                          (p == 0) ? 8'h1b : seq_char(),
                                          5'(e), 4'(p), 16'($urandom), 5'($urandom)));
      len = (e == 31) ? 31 : (e == 30) ? 0 : $urandom_range(1, 6);
      pending_words.push_back(make_word(ksm_pkg::OP_WR_CODE, 8'($urandom), 5'(e),
                                        4'($urandom), 16'($urandom), 5'(len)));
    end
  endfunction

  function automatic void add_random(int count);
    int k;
    int e;
    int n;
    k = 0;
    n = (active_count() == 0) ? 1 : active_count();
    while (k < count) begin
      case ($urandom_range(0, 13))
        0, 1, 2, 3, 4, 5, 6, 7: begin
          e = $urandom_range(0, n - 1);
          send_entry(e, ($urandom_range(0, 3) == 0) ? $urandom_range(1, ksm_pkg::MAX_LEN)
                                                    : ksm_pkg::MAX_LEN);
          if ($urandom_range(0, 2) == 0) pending_words.push_back(tick_word());
          k += (seq_len[e] == 0) ? 1 : seq_len[e];
        end
        8, 9: begin
          pending_words.push_back(key_word(($urandom_range(0, 1) == 0) ? seq_char()
                                                                   : 8'($urandom)));
          k++;
        end
        10: begin
          pending_words.push_back(tick_word());
          k++;
        end
        11, 12: begin
          pending_words.push_back(make_word(ksm_pkg::OP_WR_CHAR, seq_char(), 5'($urandom),
                                            4'($urandom), 16'($urandom), 5'($urandom)));
          k++;
        end
        default: begin
          pending_words.push_back(make_word(ksm_pkg::OP_WR_CODE, 8'($urandom),
                                            5'($urandom), 4'($urandom), 16'($urandom),
                                            5'($urandom_range(0, 6))));
          k++;
        end
      endcase
    end
  endfunction

  initial begin
    int cfg_n [5] = '{32, 5, 63, 1, 20};
    bit cfg_d [5] = '{0, 1, 0, 0, 1};
    errors = 0;
    idle_cnt = 0;
    stall_cnt = 0;
    quiet_cnt = 0;
    watchdog = 0;
    quiet = 1'b0;
    in_fire = 1'b0;
    kcount = 0;
    live = '1;
    entries_cfg = 0;
    discard_cfg = 1'b0;
    for (int e = 0; e < ksm_pkg::N_ENTRIES; e++) seq_len[e] = 0;
    key_in.valid = 1'b0;
    key_in.data = '0;
    res_out.ready = 1'b1;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // pass-through with no entries in use, discard on and off
    write_reg(ksm_pkg::REG_DISCARD, 6'd1);
    pending_words.push_back(key_word(8'h00));
    pending_words.push_back(key_word(8'hff));
    pending_words.push_back(tick_word());
    pending_words.push_back(key_word(8'h1b));
    drain();
    write_reg(ksm_pkg::REG_DISCARD, 6'd0);
    pending_words.push_back(key_word(8'ha5));
    pending_words.push_back(key_word(8'h5a));
    load_table();
    drain();

    // directed matching cases
    write_reg(ksm_pkg::REG_ENTRIES, 6'd32);
    send_entry(31, ksm_pkg::MAX_LEN);
    send_entry(3, ksm_pkg::MAX_LEN);
    send_entry(31, 4);
    pending_words.push_back(tick_word());
    pending_words.push_back(tick_word());
    pending_words.push_back(tick_word());
    pending_words.push_back(key_word(8'h1b));
    pending_words.push_back(key_word(8'h00));
    pending_words.push_back(key_word(8'hff));
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(ksm_pkg::REG_ENTRIES, 6'(cfg_n[ph]));
      write_reg(ksm_pkg::REG_DISCARD, 6'(cfg_d[ph]));
      if (ph == 4) quiet = 1'b1;
      add_random(45);
      drain();
    end

    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ksm_pkg.sv
hdl/ksm_if.sv
hdl/key_sequence_matcher.sv
tb/tb_top.sv
